// File: rtl/rgsd_pkg.sv
// Shared types and constants for the run-length glyph span decoder.
package rgsd_pkg;

    localparam int DIM_W   = 7;
    localparam int COORD_W = 16;
    localparam int WORD_W  = 32;
    localparam int RUN_W   = 16;
    localparam int LIT_W   = 9;

    localparam logic [WORD_W-1:0] LIT_HDR_MASK = 32'hFFFF_FF00;
    localparam logic [LIT_W-1:0]  LIT_RUN_BASE = 9'h100;

    localparam logic [1:0] MODE_HEADER  = 2'd0;
    localparam logic [1:0] MODE_LITERAL = 2'd1;
    localparam logic [1:0] MODE_REPEAT  = 2'd2;

    typedef struct packed {
        logic               start_glyph;
        logic [DIM_W-1:0]   glyph_width;
        logic [DIM_W-1:0]   glyph_height;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [WORD_W-1:0]  data_word;
    } word_t;

    typedef struct packed {
        logic [COORD_W-1:0] span_x;
        logic [COORD_W-1:0] span_y;
        logic [DIM_W-1:0]   span_length;
        logic [WORD_W-1:0]  span_color;
        logic               glyph_done;
        logic               last;
    } span_t;

    typedef struct packed {
        logic load;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic spans_due;
        logic out_free;
        logic step_last;
    } sts_t;

endpackage

// File: rtl/rgsd_chan_if.sv
// Valid/ready channel carrying one payload per request.
interface rgsd_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/rgsd_ctrl.sv
// Controller: takes words and sequences the span steps of each one.
module rgsd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rgsd_pkg::sts_t sts,
    output rgsd_pkg::cmd_t cmd
);
    import rgsd_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SPAN = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        in_ready   = (state_reg == S_IDLE);
        cmd.load   = in_valid && (state_reg == S_IDLE);
        cmd.step   = (state_reg == S_SPAN) && sts.out_free;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load && sts.spans_due)
                begin
                    state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                if (cmd.step && sts.step_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/rgsd_dpath.sv
// Datapath: run decoding, glyph cursor, span splitting and output register.
module rgsd_dpath #(
    parameter int MAX_GLYPH_WIDTH  = 64,
    parameter int MAX_GLYPH_HEIGHT = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rgsd_pkg::word_t word,
    input  rgsd_pkg::cmd_t  cmd,
    output rgsd_pkg::sts_t  sts,
    input  logic            out_ready,
    output logic            out_valid,
    output rgsd_pkg::span_t span
);
    import rgsd_pkg::*;

    // The width field cannot exceed its own 7-bit range, whatever the limit.
    localparam int DIM_MAX = (1 << DIM_W) - 1;
    localparam int EFF_W   = (MAX_GLYPH_WIDTH < DIM_MAX) ? MAX_GLYPH_WIDTH : DIM_MAX;
    localparam int EFF_H   = MAX_GLYPH_HEIGHT;
    localparam int COL_W   = (EFF_W > 1) ? $clog2(EFF_W) : 1;
    localparam int ROW_W   = $clog2(EFF_H + 1);
    localparam int PIX_W   = $clog2(EFF_W * EFF_H + 1);
    localparam int SUM_W   = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;

    logic [1:0]         mode_reg,      mode_next;
    logic [LIT_W-1:0]   run_left_reg,  run_left_next;
    logic [RUN_W-1:0]   repeat_reg,    repeat_next;
    logic [RUN_W-1:0]   span_left_reg, span_left_next;
    logic [WORD_W-1:0]  color_reg,     color_next;
    logic [COL_W-1:0]   col_reg,       col_next;
    logic [ROW_W-1:0]   row_reg,       row_next;
    logic [PIX_W-1:0]   emitted_reg,   emitted_next;
    logic [DIM_W-1:0]   width_reg,     width_next;
    logic [PIX_W-1:0]   total_reg,     total_next;
    logic [COORD_W-1:0] ox_reg,        ox_next;
    logic [COORD_W-1:0] oy_reg,        oy_next;
    logic               finished_reg,  finished_next;
    logic               out_valid_reg, out_valid_next;
    span_t              out_reg,       out_next;

    logic [DIM_W-1:0]   w_clamp;
    logic [DIM_W-1:0]   h_clamp;
    logic [2*DIM_W-1:0] area;
    logic               eff_fin;
    logic [1:0]         eff_mode;
    logic               lit_hdr;
    logic [RUN_W-1:0]   room_row;
    logic [RUN_W-1:0]   room_pix;
    logic [RUN_W-1:0]   n_wide;
    logic [DIM_W-1:0]   n;
    logic [SUM_W-1:0]   col_sum;
    logic [PIX_W:0]     emitted_sum;
    logic               done;

    always_comb
    begin
        if (word.glyph_width == '0)
        begin
            w_clamp = DIM_W'(1);
        end
        else if (word.glyph_width > DIM_W'(EFF_W))
        begin
            w_clamp = DIM_W'(EFF_W);
        end
        else
        begin
            w_clamp = word.glyph_width;
        end

        if (word.glyph_height == '0)
        begin
            h_clamp = DIM_W'(1);
        end
        else if (word.glyph_height > DIM_W'(EFF_H))
        begin
            h_clamp = DIM_W'(EFF_H);
        end
        else
        begin
            h_clamp = word.glyph_height;
        end
    end

    assign area = w_clamp * h_clamp;

    // A start word resets the glyph before it is decoded as a header.
    assign eff_fin  = word.start_glyph ? 1'b0 : finished_reg;
    assign eff_mode = word.start_glyph ? MODE_HEADER : mode_reg;
    assign lit_hdr  = ((word.data_word & LIT_HDR_MASK) == LIT_HDR_MASK);

    // A span stops at the row end, the run end or the glyph end.
    always_comb
    begin
        room_row = RUN_W'(width_reg - DIM_W'(col_reg));
        room_pix = RUN_W'(total_reg - emitted_reg);
        n_wide   = span_left_reg;
        if (room_row < n_wide)
        begin
            n_wide = room_row;
        end
        if (room_pix < n_wide)
        begin
            n_wide = room_pix;
        end
        n           = n_wide[DIM_W-1:0];
        col_sum     = SUM_W'(col_reg) + SUM_W'(n);
        emitted_sum = {1'b0, emitted_reg} + (PIX_W+1)'(n);
        done        = (emitted_sum >= {1'b0, total_reg});
    end

    always_comb
    begin
        sts.spans_due = !eff_fin && ((eff_mode == MODE_LITERAL) ||
                        ((eff_mode == MODE_REPEAT) && (repeat_reg != '0)));
        sts.out_free  = !out_valid_reg || out_ready;
        sts.step_last = done || (span_left_reg == RUN_W'(n));
    end

    always_comb
    begin
        mode_next      = mode_reg;
        run_left_next  = run_left_reg;
        repeat_next    = repeat_reg;
        span_left_next = span_left_reg;
        color_next     = color_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        emitted_next   = emitted_reg;
        width_next     = width_reg;
        total_next     = total_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        finished_next  = finished_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.load)
        begin
            if (word.start_glyph)
            begin
                width_next    = w_clamp;
                total_next    = PIX_W'(area);
                ox_next       = word.origin_x;
                oy_next       = word.origin_y;
                col_next      = '0;
                row_next      = '0;
                emitted_next  = '0;
                run_left_next = '0;
                repeat_next   = '0;
                finished_next = 1'b0;
                mode_next     = MODE_HEADER;
            end
            if (!eff_fin)
            begin
                color_next = word.data_word;
                unique case (eff_mode)
                    MODE_HEADER:
                    begin
                        if (lit_hdr)
                        begin
                            run_left_next = LIT_RUN_BASE - LIT_W'(word.data_word[7:0]);
                            mode_next     = MODE_LITERAL;
                        end
                        else
                        begin
                            repeat_next = word.data_word[RUN_W-1:0];
                            mode_next   = MODE_REPEAT;
                        end
                    end
                    MODE_LITERAL:
                    begin
                        span_left_next = RUN_W'(1);
                    end
                    default:
                    begin
                        // A zero-length repeat still consumes its color word.
                        span_left_next = repeat_reg;
                        if (repeat_reg == '0)
                        begin
                            mode_next = MODE_HEADER;
                        end
                    end
                endcase
            end
        end

        if (cmd.step)
        begin
            out_next.span_x      = ox_reg + COORD_W'(col_reg);
            out_next.span_y      = oy_reg + COORD_W'(row_reg);
            out_next.span_length = n;
            out_next.span_color  = color_reg;
            out_next.glyph_done  = done;
            out_next.last        = sts.step_last;
            out_valid_next       = 1'b1;

            if (col_sum == SUM_W'(width_reg))
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_sum[COL_W-1:0];
            end
            emitted_next   = emitted_sum[PIX_W-1:0];
            span_left_next = span_left_reg - RUN_W'(n);

            if (done)
            begin
                finished_next = 1'b1;
                mode_next     = MODE_HEADER;
            end
            else if (sts.step_last)
            begin
                if (mode_reg == MODE_LITERAL)
                begin
                    run_left_next = run_left_reg - LIT_W'(1);
                    if (run_left_reg == LIT_W'(1))
                    begin
                        mode_next = MODE_HEADER;
                    end
                end
                else
                begin
                    repeat_next = '0;
                    mode_next   = MODE_HEADER;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_HEADER;
            run_left_reg  <= '0;
            repeat_reg    <= '0;
            span_left_reg <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            emitted_reg   <= '0;
            width_reg     <= DIM_W'(1);
            total_reg     <= PIX_W'(1);
            ox_reg        <= '0;
            oy_reg        <= '0;
            finished_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            run_left_reg  <= run_left_next;
            repeat_reg    <= repeat_next;
            span_left_reg <= span_left_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            emitted_reg   <= emitted_next;
            width_reg     <= width_next;
            total_reg     <= total_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        color_reg <= color_next;
        out_reg   <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign span      = out_reg;

endmodule

// File: rtl/rle_glyph_span_decoder.sv
// Top level of the run-length glyph span decoder.
//
//   Channel   Role    Payload
//   words     sink    start_glyph, glyph_width, glyph_height, origin_x, origin_y, data_word
//   spans     source  span_x, span_y, span_length, span_color, glyph_done, last
//
// A header word, or any word while no glyph is open, is taken without forming a span.
// A literal pixel word is taken first and then forms its single span.
// A repeat color word is taken first and then forms one span for each glyph row the
// run touches, since a single span unit forms one span per cycle while the output is free.
// Reset clears the decoder to "glyph finished"; words are ignored until a start.
// A stalled span holds in the output register; a new word is taken once the
// last span of the previous word sits there.
module rle_glyph_span_decoder #(
    parameter int MAX_GLYPH_WIDTH  = 64,
    parameter int MAX_GLYPH_HEIGHT = 64
) (
    input logic         clk,
    input logic         rst_n,
    rgsd_chan_if.sink   words,
    rgsd_chan_if.source spans
);
    import rgsd_pkg::*;

    cmd_t cmd;
    sts_t sts;

    rgsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (words.valid),
        .in_ready (words.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rgsd_dpath #(
        .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .word      (words.payload),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (spans.ready),
        .out_valid (spans.valid),
        .span      (spans.payload)
    );

endmodule

// File: rtl/rgsd_checker.sv
// Port-level checks for the glyph span decoder, bound to the top level.
module rgsd_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            spans_valid,
    input logic            spans_ready,
    input rgsd_pkg::span_t span
);
    import rgsd_pkg::*;

    // A stalled request keeps its valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        spans_valid && !spans_ready |=> spans_valid)
        else $error("span request dropped while stalled");

    // A stalled request keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        spans_valid && !spans_ready |=> $stable(span))
        else $error("span payload changed while stalled");

    // Every span paints at least one pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        spans_valid |-> (span.span_length != '0))
        else $error("empty span");

    // Finishing the glyph ends the work of the current word.
    assert property (@(posedge clk) disable iff (!rst_n)
        spans_valid && span.glyph_done |-> span.last)
        else $error("glyph finished on a span that is not the last");

endmodule

bind rle_glyph_span_decoder rgsd_checker u_rgsd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .spans_valid (spans.valid),
    .spans_ready (spans.ready),
    .span        (spans.payload)
);
